// ===== rtl/core/uoas_pkg.sv =====
// shared types and constants for the obstacle avoid sequencer
package uoas_pkg;

    // distance result width and saturation value
    localparam int unsigned DIST_W = 10;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // configuration register indexes
    localparam logic [2:0] CFG_THRESHOLD   = 3'd0;
    localparam logic [2:0] CFG_CRUISE_DUTY = 3'd1;
    localparam logic [2:0] CFG_TURN_DUTY   = 3'd2;
    localparam logic [2:0] CFG_STOP_MS     = 3'd3;
    localparam logic [2:0] CFG_RIGHT_MS    = 3'd4;
    localparam logic [2:0] CFG_LEFT_MS     = 3'd5;
    localparam logic [2:0] CFG_PAUSE_MS    = 3'd6;
    localparam logic [2:0] CFG_FWAIT_MS    = 3'd7;

    // configuration reset values
    localparam logic [9:0]  RST_THRESHOLD   = 10'd15;
    localparam logic [7:0]  RST_CRUISE_DUTY = 8'h4C;
    localparam logic [7:0]  RST_TURN_DUTY   = 8'h66;
    localparam logic [15:0] RST_STOP_MS     = 16'd2000;
    localparam logic [15:0] RST_RIGHT_MS    = 16'd500;
    localparam logic [15:0] RST_LEFT_MS     = 16'd1000;
    localparam logic [15:0] RST_PAUSE_MS    = 16'd100;
    localparam logic [15:0] RST_FWAIT_MS    = 16'd100;
    localparam logic [7:0]  RST_DUTY        = 8'h33;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ECHO = 1'b1;

    // motor drive patterns: bit0 left fwd, bit1 left back, bit2 right fwd, bit3 right back
    localparam logic [3:0] DRV_OFF     = 4'h0;
    localparam logic [3:0] DRV_FORWARD = 4'h5;
    localparam logic [3:0] DRV_RIGHT   = 4'h9;
    localparam logic [3:0] DRV_LEFT    = 4'h6;

    // phase codes as seen on the result
    localparam logic [2:0] PH_MEASURE = 3'd0;
    localparam logic [2:0] PH_FWAIT   = 3'd1;
    localparam logic [2:0] PH_STOP    = 3'd2;
    localparam logic [2:0] PH_RIGHT   = 3'd3;
    localparam logic [2:0] PH_LEFT    = 3'd4;
    localparam logic [2:0] PH_PAUSE   = 3'd5;

    // sequencer mode, one-hot
    typedef enum logic [5:0] {
        MODE_MEASURE = 6'b000001,
        MODE_FWAIT   = 6'b000010,
        MODE_STOP    = 6'b000100,
        MODE_RIGHT   = 6'b001000,
        MODE_LEFT    = 6'b010000,
        MODE_PAUSE   = 6'b100000
    } t_mode;

    // mode to phase code
    function automatic logic [2:0] mode_phase(input t_mode mode);
        logic [2:0] ph;
        unique case (mode)
            MODE_MEASURE: ph = PH_MEASURE;
            MODE_FWAIT:   ph = PH_FWAIT;
            MODE_STOP:    ph = PH_STOP;
            MODE_RIGHT:   ph = PH_RIGHT;
            MODE_LEFT:    ph = PH_LEFT;
            MODE_PAUSE:   ph = PH_PAUSE;
            default:      ph = PH_MEASURE;
        endcase
        return ph;
    endfunction

endpackage

// ===== rtl/core/ultrasonic_obstacle_avoid_sequencer.sv =====
// obstacle avoid sequencer: echo distance pipeline and motor sequencing state
//
// Each request is a millisecond tick or an echo measurement (rise and fall timer
// counts). The block takes one request per cycle while the result side is not
// stalled and returns exactly one result per request, in order. Each request
// passes through the distance path: input register, absolute difference, scale
// multiply, reciprocal multiply for the constant divide, then the sequencer
// state register, which is also the result register. A stall on the result side
// holds the whole pipeline. Distance saturates at 1023 cm.
module ultrasonic_obstacle_avoid_sequencer #(
    parameter int unsigned TIMER_WIDTH = 16,
    parameter int unsigned SCALE_MUL   = 170,
    parameter int unsigned SCALE_DIV   = 20000
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [15:0]            i_cfg_data,
    // request channel
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_operation,
    input  logic [TIMER_WIDTH-1:0] i_rise_time,
    input  logic [TIMER_WIDTH-1:0] i_fall_time,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_left_fwd,
    output logic                   o_left_back,
    output logic                   o_right_fwd,
    output logic                   o_right_back,
    output logic [7:0]             o_duty,
    output logic                   o_obstacle_led,
    output logic                   o_measure_request,
    output logic [9:0]             o_distance_cm,
    output logic [2:0]             o_phase
);

    localparam int unsigned DIST_W = uoas_pkg::DIST_W;
    localparam int unsigned MUL_W  = $clog2(SCALE_MUL + 1);
    localparam int unsigned PROD_W = TIMER_WIDTH + MUL_W;
    localparam int unsigned DIV_W  = $clog2(SCALE_DIV + 1);
    localparam int unsigned DIV_L  = $clog2(SCALE_DIV);
    // unsaturated products stay below 1024 * SCALE_DIV
    localparam int unsigned P_W    = DIST_W + DIV_W;
    localparam int unsigned SHIFT  = P_W + DIV_L;
    localparam int unsigned M_W    = P_W + 1;
    localparam int unsigned Q_W    = P_W + M_W;
    localparam logic [MUL_W-1:0]  MUL_C   = MUL_W'(SCALE_MUL);
    localparam logic [63:0]       SAT_LIM = 64'(SCALE_DIV) << DIST_W;
    localparam logic [63:0]       RECIP64 = ((64'd1 << SHIFT) + 64'(SCALE_DIV) - 64'd1)
                                            / 64'(SCALE_DIV);
    localparam logic [M_W-1:0]    RECIP   = M_W'(RECIP64);

    // pipeline advance
    logic r_out_vld;
    logic en;
    assign en = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;

    // stage 0: input register
    logic                   r_s0_vld;
    logic                   r_s0_op;
    logic [TIMER_WIDTH-1:0] r_s0_rise;
    logic [TIMER_WIDTH-1:0] r_s0_fall;

    // stage 1: absolute difference
    logic                   r_s1_vld;
    logic                   r_s1_op;
    logic [TIMER_WIDTH-1:0] r_s1_diff;
    logic [TIMER_WIDTH-1:0] n_s1_diff;

    // stage 2: scaled product
    logic                   r_s2_vld;
    logic                   r_s2_op;
    logic [PROD_W-1:0]      r_s2_prod;
    logic [PROD_W-1:0]      n_s2_prod;

    // stage 3: reciprocal product and saturation flag
    logic                   r_s3_vld;
    logic                   r_s3_op;
    logic [Q_W-1:0]         r_s3_q;
    logic                   r_s3_sat;
    logic [Q_W-1:0]         n_s3_q;
    logic                   n_s3_sat;
    logic [P_W-1:0]         s2_plo;

    assign n_s1_diff = (r_s0_fall > r_s0_rise) ? (r_s0_fall - r_s0_rise)
                                               : (r_s0_rise - r_s0_fall);
    assign n_s2_prod = PROD_W'(r_s1_diff) * PROD_W'(MUL_C);
    assign s2_plo    = P_W'(r_s2_prod);
    assign n_s3_q    = Q_W'(s2_plo) * Q_W'(RECIP);
    assign n_s3_sat  = 64'(r_s2_prod) >= SAT_LIM;

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld  <= i_in_valid;
            r_s1_vld  <= r_s0_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_op   <= i_operation;
            r_s0_rise <= i_rise_time;
            r_s0_fall <= i_fall_time;
            r_s1_op   <= r_s0_op;
            r_s1_diff <= n_s1_diff;
            r_s2_op   <= r_s1_op;
            r_s2_prod <= n_s2_prod;
            r_s3_op   <= r_s2_op;
            r_s3_q    <= n_s3_q;
            r_s3_sat  <= n_s3_sat;
        end
    end

    // configuration registers
    logic [9:0]  r_threshold;
    logic [7:0]  r_cruise_duty;
    logic [7:0]  r_turn_duty;
    logic [15:0] r_stop_ms;
    logic [15:0] r_right_ms;
    logic [15:0] r_left_ms;
    logic [15:0] r_pause_ms;
    logic [15:0] r_fwait_ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= uoas_pkg::RST_THRESHOLD;
            r_cruise_duty <= uoas_pkg::RST_CRUISE_DUTY;
            r_turn_duty   <= uoas_pkg::RST_TURN_DUTY;
            r_stop_ms     <= uoas_pkg::RST_STOP_MS;
            r_right_ms    <= uoas_pkg::RST_RIGHT_MS;
            r_left_ms     <= uoas_pkg::RST_LEFT_MS;
            r_pause_ms    <= uoas_pkg::RST_PAUSE_MS;
            r_fwait_ms    <= uoas_pkg::RST_FWAIT_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                uoas_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data[9:0];
                uoas_pkg::CFG_CRUISE_DUTY: r_cruise_duty <= i_cfg_data[7:0];
                uoas_pkg::CFG_TURN_DUTY:   r_turn_duty   <= i_cfg_data[7:0];
                uoas_pkg::CFG_STOP_MS:     r_stop_ms     <= i_cfg_data;
                uoas_pkg::CFG_RIGHT_MS:    r_right_ms    <= i_cfg_data;
                uoas_pkg::CFG_LEFT_MS:     r_left_ms     <= i_cfg_data;
                uoas_pkg::CFG_PAUSE_MS:    r_pause_ms    <= i_cfg_data;
                uoas_pkg::CFG_FWAIT_MS:    r_fwait_ms    <= i_cfg_data;
            endcase
        end
    end

    // sequencer state, which also forms the result register
    uoas_pkg::t_mode r_mode, n_mode;
    logic            r_fwd_run, n_fwd_run;
    logic [15:0]     r_countdown, n_countdown;
    logic            r_turn_left, n_turn_left;
    logic [9:0]      r_last_dist, n_last_dist;
    logic [7:0]      r_duty, n_duty;
    logic [3:0]      r_drive, n_drive;
    logic            r_led, n_led;
    logic [9:0]      s3_dist;

    assign s3_dist = r_s3_sat ? uoas_pkg::DIST_MAX : r_s3_q[SHIFT +: DIST_W];

    // next state for the request leaving stage 3
    always_comb begin
        n_mode      = r_mode;
        n_fwd_run   = r_fwd_run;
        n_countdown = r_countdown;
        n_turn_left = r_turn_left;
        n_last_dist = r_last_dist;
        n_duty      = r_duty;
        n_drive     = r_drive;
        n_led       = r_led;
        if (r_s3_vld) begin
            if (r_s3_op == uoas_pkg::OP_ECHO) begin
                // echo only counts while measuring
                if (r_mode == uoas_pkg::MODE_MEASURE) begin
                    n_last_dist = s3_dist;
                    if (r_fwd_run) begin
                        n_mode      = uoas_pkg::MODE_FWAIT;
                        n_countdown = r_fwait_ms;
                    end else if (s3_dist > r_threshold) begin
                        n_led     = 1'b0;
                        n_duty    = r_cruise_duty;
                        n_drive   = uoas_pkg::DRV_FORWARD;
                        n_mode    = uoas_pkg::MODE_MEASURE;
                        n_fwd_run = 1'b1;
                    end else begin
                        n_led       = 1'b1;
                        n_drive     = uoas_pkg::DRV_OFF;
                        n_mode      = uoas_pkg::MODE_STOP;
                        n_countdown = r_stop_ms;
                    end
                end
            end else if (r_mode != uoas_pkg::MODE_MEASURE) begin
                if (r_countdown > 16'd1) begin
                    n_countdown = r_countdown - 16'd1;
                end else begin
                    // timed phase ends
                    unique case (r_mode)
                        uoas_pkg::MODE_FWAIT: begin
                            if (r_last_dist > r_threshold) begin
                                n_led     = 1'b0;
                                n_duty    = r_cruise_duty;
                                n_drive   = uoas_pkg::DRV_FORWARD;
                                n_mode    = uoas_pkg::MODE_MEASURE;
                                n_fwd_run = 1'b1;
                            end else begin
                                n_led       = 1'b1;
                                n_drive     = uoas_pkg::DRV_OFF;
                                n_mode      = uoas_pkg::MODE_STOP;
                                n_countdown = r_stop_ms;
                            end
                        end
                        uoas_pkg::MODE_STOP: begin
                            n_duty      = r_turn_duty;
                            n_turn_left = !r_turn_left;
                            if (r_turn_left) begin
                                n_drive     = uoas_pkg::DRV_LEFT;
                                n_mode      = uoas_pkg::MODE_LEFT;
                                n_countdown = r_left_ms;
                            end else begin
                                n_drive     = uoas_pkg::DRV_RIGHT;
                                n_mode      = uoas_pkg::MODE_RIGHT;
                                n_countdown = r_right_ms;
                            end
                        end
                        uoas_pkg::MODE_RIGHT, uoas_pkg::MODE_LEFT: begin
                            n_drive     = uoas_pkg::DRV_OFF;
                            n_mode      = uoas_pkg::MODE_PAUSE;
                            n_countdown = r_pause_ms;
                        end
                        default: begin
                            n_mode      = uoas_pkg::MODE_MEASURE;
                            n_fwd_run   = 1'b0;
                            n_countdown = 16'd0;
                        end
                    endcase
                end
            end
        end
    end

    // state update, held while the result is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= uoas_pkg::MODE_MEASURE;
            r_fwd_run   <= 1'b0;
            r_countdown <= 16'd0;
            r_turn_left <= 1'b0;
            r_last_dist <= '0;
            r_duty      <= uoas_pkg::RST_DUTY;
            r_drive     <= uoas_pkg::DRV_OFF;
            r_led       <= 1'b0;
        end else if (en) begin
            r_mode      <= n_mode;
            r_fwd_run   <= n_fwd_run;
            r_countdown <= n_countdown;
            r_turn_left <= n_turn_left;
            r_last_dist <= n_last_dist;
            r_duty      <= n_duty;
            r_drive     <= n_drive;
            r_led       <= n_led;
        end
    end

    // result fields
    assign o_left_fwd        = r_drive[0];
    assign o_left_back       = r_drive[1];
    assign o_right_fwd       = r_drive[2];
    assign o_right_back      = r_drive[3];
    assign o_duty            = r_duty;
    assign o_obstacle_led    = r_led;
    assign o_measure_request = (r_mode == uoas_pkg::MODE_MEASURE);
    assign o_distance_cm     = r_last_dist;
    assign o_phase           = uoas_pkg::mode_phase(r_mode);

endmodule

// ===== verif/ultrasonic_obstacle_avoid_sequencer_tb.sv =====
// self-checking testbench for the obstacle avoid sequencer
`timescale 1ns / 1ps

module ultrasonic_obstacle_avoid_sequencer_tb;

    localparam int unsigned CM_MUL  = 170;
    localparam int unsigned CM_DIV  = 20000;
    localparam int unsigned CM_TOP  = 557;     // largest distance a 16-bit span can give
    localparam int unsigned SETTLE  = 16;
    localparam int unsigned LIMIT   = 400000;
    localparam int unsigned N_RAND  = 193;     // acted-on requests per random setting

    typedef struct {
        logic        op;
        logic [15:0] rise;
        logic [15:0] fall;
    } t_sonar_req;

    typedef struct {
        logic       left_fwd;
        logic       left_back;
        logic       right_fwd;
        logic       right_back;
        logic [7:0] duty;
        logic       led;
        logic       measure_req;
        logic [9:0] dist_cm;
        logic [2:0] phase;
    } t_nav_result;

    // dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_operation = 1'b0;
    logic [15:0] i_rise_time = '0;
    logic [15:0] i_fall_time = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_left_fwd;
    logic        o_left_back;
    logic        o_right_fwd;
    logic        o_right_back;
    logic [7:0]  o_duty;
    logic        o_obstacle_led;
    logic        o_measure_request;
    logic [9:0]  o_distance_cm;
    logic [2:0]  o_phase;

    ultrasonic_obstacle_avoid_sequencer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_rise_time       (i_rise_time),
        .i_fall_time       (i_fall_time),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_left_fwd        (o_left_fwd),
        .o_left_back       (o_left_back),
        .o_right_fwd       (o_right_fwd),
        .o_right_back      (o_right_back),
        .o_duty            (o_duty),
        .o_obstacle_led    (o_obstacle_led),
        .o_measure_request (o_measure_request),
        .o_distance_cm     (o_distance_cm),
        .o_phase           (o_phase)
    );

    always #2 i_clk = ~i_clk;

    // requests waiting to be sent, with the result each one will produce
    t_sonar_req  sonar_queue[$];
    t_nav_result sonar_pred[$];
    // results owed by the dut for requests already accepted
    t_nav_result nav_due[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned n_acted = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_fail = 0;
    int unsigned n_settings = 0;
    int unsigned n_cycles = 0;
    int unsigned phase_seen[6];

    // predictor configuration copy
    logic [9:0]  cfg_thresh = uoas_pkg::RST_THRESHOLD;
    logic [7:0]  cfg_cruise = uoas_pkg::RST_CRUISE_DUTY;
    logic [7:0]  cfg_turn   = uoas_pkg::RST_TURN_DUTY;
    logic [15:0] cfg_stop   = uoas_pkg::RST_STOP_MS;
    logic [15:0] cfg_right  = uoas_pkg::RST_RIGHT_MS;
    logic [15:0] cfg_left   = uoas_pkg::RST_LEFT_MS;
    logic [15:0] cfg_pause  = uoas_pkg::RST_PAUSE_MS;
    logic [15:0] cfg_fwait  = uoas_pkg::RST_FWAIT_MS;
    logic [15:0] cfg_plan[8];

    // predictor sequencing state
    logic [2:0]  nav_phase = uoas_pkg::PH_MEASURE;
    logic        fwd_run = 1'b0;
    logic [15:0] ms_left = '0;
    logic        turn_left_next = 1'b0;
    logic [9:0]  dist_q = '0;
    logic [7:0]  duty_q = uoas_pkg::RST_DUTY;
    logic [3:0]  drive_q = uoas_pkg::DRV_OFF;
    logic        led_q = 1'b0;

    // distance from captured echo edges, saturating
    function automatic logic [9:0] echo_to_cm(input logic [15:0] t_rise,
                                              input logic [15:0] t_fall);
        logic [15:0] span;
        logic [31:0] scaled;
        span   = (t_fall > t_rise) ? t_fall - t_rise : t_rise - t_fall;
        scaled = (32'(span) * CM_MUL) / CM_DIV;
        return (scaled > 32'(uoas_pkg::DIST_MAX)) ? uoas_pkg::DIST_MAX : scaled[9:0];
    endfunction

    task enter_forward();
        led_q     = 1'b0;
        duty_q    = cfg_cruise;
        drive_q   = uoas_pkg::DRV_FORWARD;
        nav_phase = uoas_pkg::PH_MEASURE;
        fwd_run   = 1'b1;
    endtask

    task enter_stop();
        led_q     = 1'b1;
        drive_q   = uoas_pkg::DRV_OFF;
        nav_phase = uoas_pkg::PH_STOP;
        ms_left   = cfg_stop;
    endtask

    // advance the sequencer by one request and report the visible state
    task predict_nav(input t_sonar_req rq, output t_nav_result res);
        if (rq.op == uoas_pkg::OP_ECHO) begin
            if (nav_phase == uoas_pkg::PH_MEASURE) begin
                dist_q = echo_to_cm(rq.rise, rq.fall);
                if (fwd_run) begin
                    nav_phase = uoas_pkg::PH_FWAIT;
                    ms_left   = cfg_fwait;
                end else if (dist_q > cfg_thresh) begin
                    enter_forward();
                end else begin
                    enter_stop();
                end
            end
        end else if (nav_phase != uoas_pkg::PH_MEASURE) begin
            // zero and one both end on this tick
            if (ms_left <= 16'd1) begin
                unique case (nav_phase)
                    uoas_pkg::PH_FWAIT: begin
                        if (dist_q > cfg_thresh) enter_forward();
                        else enter_stop();
                    end
                    uoas_pkg::PH_STOP: begin
                        duty_q = cfg_turn;
                        if (turn_left_next) begin
                            drive_q   = uoas_pkg::DRV_LEFT;
                            nav_phase = uoas_pkg::PH_LEFT;
                            ms_left   = cfg_left;
                        end else begin
                            drive_q   = uoas_pkg::DRV_RIGHT;
                            nav_phase = uoas_pkg::PH_RIGHT;
                            ms_left   = cfg_right;
                        end
                        turn_left_next = ~turn_left_next;
                    end
                    uoas_pkg::PH_RIGHT, uoas_pkg::PH_LEFT: begin
                        drive_q   = uoas_pkg::DRV_OFF;
                        nav_phase = uoas_pkg::PH_PAUSE;
                        ms_left   = cfg_pause;
                    end
                    default: begin
                        nav_phase = uoas_pkg::PH_MEASURE;
                        fwd_run   = 1'b0;
                        ms_left   = '0;
                    end
                endcase
            end else begin
                ms_left = ms_left - 16'd1;
            end
        end
        res.left_fwd    = drive_q[0];
        res.left_back   = drive_q[1];
        res.right_fwd   = drive_q[2];
        res.right_back  = drive_q[3];
        res.duty        = duty_q;
        res.led         = led_q;
        res.measure_req = (nav_phase == uoas_pkg::PH_MEASURE);
        res.dist_cm     = dist_q;
        res.phase       = nav_phase;
    endtask

    // stimulus helpers: each request is predicted as it is queued
    task queue_item(input logic op, input logic [15:0] t_rise, input logic [15:0] t_fall);
        t_sonar_req  rq;
        t_nav_result rs;
        if ((op == uoas_pkg::OP_ECHO) == (nav_phase == uoas_pkg::PH_MEASURE)) n_acted++;
        rq.op   = op;
        rq.rise = t_rise;
        rq.fall = t_fall;
        predict_nav(rq, rs);
        sonar_queue.push_back(rq);
        sonar_pred.push_back(rs);
    endtask

    task queue_tick();
        queue_item(uoas_pkg::OP_TICK, 16'($urandom), 16'($urandom));
    endtask

    // echo whose span lands anywhere inside the given distance bucket
    task queue_echo_cm(input int unsigned cm);
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        int unsigned t0;
        lo = (cm * CM_DIV + CM_MUL - 1) / CM_MUL;
        hi = ((cm + 1) * CM_DIV - 1) / CM_MUL;
        if (hi > 65535) hi = 65535;
        span = $urandom_range(hi, lo);
        t0   = $urandom_range(65535 - span, 0);
        if ($urandom_range(1, 0) != 0) queue_item(uoas_pkg::OP_ECHO, 16'(t0), 16'(t0 + span));
        else queue_item(uoas_pkg::OP_ECHO, 16'(t0 + span), 16'(t0));
    endtask

    // mostly sequences the block acts on, some ignored requests as noise
    task queue_random_item();
        int unsigned pick;
        int          near_cm;
        pick = $urandom_range(99, 0);
        if (nav_phase == uoas_pkg::PH_MEASURE) begin
            if (pick < 10) begin
                queue_tick();
            end else if (pick < 45) begin
                near_cm = int'(cfg_thresh) + int'($urandom_range(4, 0)) - 2;
                if (near_cm < 0) near_cm = 0;
                if (near_cm > int'(CM_TOP)) near_cm = int'(CM_TOP);
                queue_echo_cm(32'(near_cm));
            end else if (pick < 80) begin
                queue_echo_cm($urandom_range(CM_TOP, 0));
            end else begin
                queue_item(uoas_pkg::OP_ECHO, 16'($urandom), 16'($urandom));
            end
        end else if (pick < 10) begin
            queue_item(uoas_pkg::OP_ECHO, 16'($urandom), 16'($urandom));
        end else begin
            queue_tick();
        end
    endtask

    task wait_drained();
        while (sonar_queue.size() != 0 || i_in_valid || nav_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task cfg_write(input logic [2:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        unique case (idx)
            uoas_pkg::CFG_THRESHOLD:   cfg_thresh = data[9:0];
            uoas_pkg::CFG_CRUISE_DUTY: cfg_cruise = data[7:0];
            uoas_pkg::CFG_TURN_DUTY:   cfg_turn   = data[7:0];
            uoas_pkg::CFG_STOP_MS:     cfg_stop   = data;
            uoas_pkg::CFG_RIGHT_MS:    cfg_right  = data;
            uoas_pkg::CFG_LEFT_MS:     cfg_left   = data;
            uoas_pkg::CFG_PAUSE_MS:    cfg_pause  = data;
            uoas_pkg::CFG_FWAIT_MS:    cfg_fwait  = data;
        endcase
    endtask

    // write every register from the plan; narrow ones carry junk upper bits
    task apply_plan();
        for (int k = 0; k < 8; k++) cfg_write(3'(k), cfg_plan[k]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task fail_note(input string msg);
        n_fail++;
        if (n_fail <= 10) $display("mismatch @%0d: %s", n_checked, msg);
    endtask

    task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) fail_note($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    // request driver
    t_sonar_req  tx_req;
    t_nav_result tx_res;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                nav_due.push_back(tx_res);
                n_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (sonar_queue.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                    tx_req = sonar_queue.pop_front();
                    tx_res = sonar_pred.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= tx_req.op;
                    i_rise_time <= tx_req.rise;
                    i_fall_time <= tx_req.fall;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    t_nav_result rx_want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
            if (o_out_valid && i_out_ready) begin
                if (o_phase < 3'd6) phase_seen[o_phase]++;
                if (nav_due.size() == 0) begin
                    fail_note("result with no request outstanding");
                end else begin
                    rx_want = nav_due.pop_front();
                    check_field("left_fwd", 16'(rx_want.left_fwd), 16'(o_left_fwd));
                    check_field("left_back", 16'(rx_want.left_back), 16'(o_left_back));
                    check_field("right_fwd", 16'(rx_want.right_fwd), 16'(o_right_fwd));
                    check_field("right_back", 16'(rx_want.right_back), 16'(o_right_back));
                    check_field("duty", 16'(rx_want.duty), 16'(o_duty));
                    check_field("obstacle_led", 16'(rx_want.led), 16'(o_obstacle_led));
                    check_field("measure_request", 16'(rx_want.measure_req),
                                16'(o_measure_request));
                    check_field("distance_cm", 16'(rx_want.dist_cm), 16'(o_distance_cm));
                    check_field("phase", 16'(rx_want.phase), 16'(o_phase));
                end
                n_checked++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", n_cycles, nav_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus sequence
    int unsigned base_acted;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 17;
        rx_idle_pct = 63;

        // reset settings: tick while measuring, widest echo span
        @(negedge i_clk);
        queue_tick();
        queue_item(uoas_pkg::OP_ECHO, 16'h0000, 16'hFFFF);
        wait_drained();

        // short timings, zero durations, full cruise and zero turn duty
        cfg_plan[uoas_pkg::CFG_THRESHOLD]   = 16'hFC14;
        cfg_plan[uoas_pkg::CFG_CRUISE_DUTY] = 16'hA5FF;
        cfg_plan[uoas_pkg::CFG_TURN_DUTY]   = 16'h5A00;
        cfg_plan[uoas_pkg::CFG_STOP_MS]     = 16'd0;
        cfg_plan[uoas_pkg::CFG_RIGHT_MS]    = 16'd1;
        cfg_plan[uoas_pkg::CFG_LEFT_MS]     = 16'd0;
        cfg_plan[uoas_pkg::CFG_PAUSE_MS]    = 16'd2;
        cfg_plan[uoas_pkg::CFG_FWAIT_MS]    = 16'd0;
        apply_plan();

        // forward run clear then blocked at threshold, right turn, first
        // measurement blocked, left turn, first measurement clear
        @(negedge i_clk);
        queue_echo_cm(32'(cfg_thresh) + 1);
        queue_tick();
        queue_echo_cm(32'(cfg_thresh));
        queue_item(uoas_pkg::OP_ECHO, 16'hFFFF, 16'h0000);
        repeat (5) queue_tick();
        queue_tick();
        queue_echo_cm(0);
        repeat (4) queue_tick();
        queue_echo_cm(32'(cfg_thresh) + 1);
        wait_drained();

        // random settings, idling pattern changes every two settings
        for (int p = 0; p < 6; p++) begin
            unique case (p / 2)
                0: begin tx_idle_pct = 17; rx_idle_pct = 63; end
                1: begin tx_idle_pct = 63; rx_idle_pct = 17; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            cfg_plan[uoas_pkg::CFG_THRESHOLD]   = {6'($urandom), 10'($urandom_range(40, 0))};
            cfg_plan[uoas_pkg::CFG_CRUISE_DUTY] = 16'($urandom);
            cfg_plan[uoas_pkg::CFG_TURN_DUTY]   = 16'($urandom);
            cfg_plan[uoas_pkg::CFG_STOP_MS]     = 16'($urandom_range(6, 0));
            cfg_plan[uoas_pkg::CFG_RIGHT_MS]    = 16'($urandom_range(6, 0));
            cfg_plan[uoas_pkg::CFG_LEFT_MS]     = 16'($urandom_range(6, 0));
            cfg_plan[uoas_pkg::CFG_PAUSE_MS]    = 16'($urandom_range(6, 0));
            cfg_plan[uoas_pkg::CFG_FWAIT_MS]    = 16'($urandom_range(6, 0));
            if (p == 1) begin
                // never clear
                cfg_plan[uoas_pkg::CFG_THRESHOLD] = 16'hFFFF;
            end else if (p == 2) begin
                // everything at its low end but the turn duty, which is full
                cfg_plan[uoas_pkg::CFG_THRESHOLD]   = 16'h0000;
                cfg_plan[uoas_pkg::CFG_CRUISE_DUTY] = 16'h0000;
                cfg_plan[uoas_pkg::CFG_TURN_DUTY]   = 16'h00FF;
                cfg_plan[uoas_pkg::CFG_STOP_MS]     = 16'd0;
                cfg_plan[uoas_pkg::CFG_RIGHT_MS]    = 16'd0;
                cfg_plan[uoas_pkg::CFG_LEFT_MS]     = 16'd0;
                cfg_plan[uoas_pkg::CFG_PAUSE_MS]    = 16'd0;
                cfg_plan[uoas_pkg::CFG_FWAIT_MS]    = 16'd0;
            end else if (p == 4) begin
                cfg_plan[uoas_pkg::CFG_THRESHOLD] = 16'($urandom_range(CM_TOP, 300));
            end
            apply_plan();
            @(negedge i_clk);
            base_acted = n_acted;
            while (n_acted - base_acted < N_RAND) queue_random_item();
            wait_drained();
        end

        // longest timings and full duties, only a short stretch of requests
        cfg_plan[uoas_pkg::CFG_THRESHOLD]   = 16'h03FF;
        cfg_plan[uoas_pkg::CFG_CRUISE_DUTY] = 16'h00FF;
        cfg_plan[uoas_pkg::CFG_TURN_DUTY]   = 16'hFFFF;
        cfg_plan[uoas_pkg::CFG_STOP_MS]     = 16'hFFFF;
        cfg_plan[uoas_pkg::CFG_RIGHT_MS]    = 16'hFFFF;
        cfg_plan[uoas_pkg::CFG_LEFT_MS]     = 16'hFFFF;
        cfg_plan[uoas_pkg::CFG_PAUSE_MS]    = 16'hFFFF;
        cfg_plan[uoas_pkg::CFG_FWAIT_MS]    = 16'hFFFF;
        apply_plan();
        @(negedge i_clk);
        base_acted = n_acted;
        while (n_acted - base_acted < 40) queue_random_item();
        wait_drained();

        if (nav_due.size() != 0) fail_note("results never returned");
        $display("sent %0d requests (%0d acted on) over %0d settings, checked %0d results",
                 n_sent, n_acted, n_settings, n_checked);
        $display("phases seen: measure %0d fwait %0d stop %0d right %0d left %0d pause %0d",
                 phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3],
                 phase_seen[4], phase_seen[5]);
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
